### hdl/assert_macros.svh
// assertion shorthands used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while the enable expression is low
`define ASSERT_IMPLY(lbl, clk, en, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(en)) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while the enable expression is low
`define ASSERT_NEXT(lbl, clk, en, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/npfe_pkg.sv
package npfe_pkg;

  // default sizes
  localparam int SENTENCE_BYTES_DEF  = 64;
  localparam int MAX_FIELD_CHARS_DEF = 15;

  // characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_A      = 8'h41;

  // result tags
  typedef enum logic [2:0] {
    TAG_LAT     = 3'd0,
    TAG_LAT_HEM = 3'd1,
    TAG_LON     = 3'd2,
    TAG_LON_HEM = 3'd3,
    TAG_VOID    = 3'd4,
    TAG_END     = 3'd5
  } tag_t;

  // sentence kind found in the header
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RMC  = 2'd1,
    KIND_GGA  = 2'd2
  } kind_t;

  typedef struct packed {
    tag_t       tag;
    logic [7:0] char_value;
    logic       sentence_type;
    logic       last;
  } result_t;

  // results produced by one processed byte
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hdl/npfe_ifs.sv
// received byte channel
interface npfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink   (input valid, input byte_value, output ready);
endinterface

// extracted result channel
interface npfe_res_if import npfe_pkg::*; ;
  logic       valid;
  logic       ready;
  tag_t       tag;
  logic [7:0] char_value;
  logic       sentence_type;
  logic       last;

  modport source (output valid, output tag, output char_value, output sentence_type,
                  output last, input ready);
  modport sink   (input valid, input tag, input char_value, input sentence_type,
                  input last, output ready);
endinterface

### hdl/npfe_core.sv
module npfe_core import npfe_pkg::*; #(
  parameter int SENTENCE_BYTES  = SENTENCE_BYTES_DEF,
  parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  output logic       byte_ready,
  input  logic       buf_space,
  output push_t      push
);

  localparam int IDX_W = $clog2(SENTENCE_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SENTENCE_BYTES - 1);
  localparam logic [3:0] MAXC = 4'(MAX_FIELD_CHARS);

  logic             in_vld_r;
  logic [7:0]       in_byte_r;

  logic             in_sentence_r, in_sentence_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       type3_r, type3_nxt;
  kind_t            kind_r, kind_nxt;
  logic [3:0]       comma_r, comma_nxt;
  logic [3:0]       fcc_r, fcc_nxt;
  logic             stopped_r, stopped_nxt;

  logic             is_comma;
  logic             f_emit;
  tag_t             f_tag;
  logic             end_emit;
  logic [3:0]       lat_f;
  logic [1:0]       nres;
  result_t          res0, res1;
  logic             fire;
  logic             stype;

  // per-byte parse step
  always_comb begin
    in_sentence_nxt = in_sentence_r;
    idx_nxt         = idx_r;
    type3_nxt       = type3_r;
    kind_nxt        = kind_r;
    comma_nxt       = comma_r;
    fcc_nxt         = fcc_r;
    stopped_nxt     = stopped_r;
    is_comma        = (in_byte_r == CH_COMMA);
    f_emit          = 1'b0;
    f_tag           = TAG_LAT;
    end_emit        = 1'b0;
    lat_f           = (kind_r == KIND_RMC) ? 4'd3 : 4'd2;

    if (!in_sentence_r) begin
      if (in_byte_r == CH_DOLLAR) begin
        in_sentence_nxt = 1'b1;
        idx_nxt         = '0;
        type3_nxt       = '0;
        kind_nxt        = KIND_NONE;
        comma_nxt       = '0;
        fcc_nxt         = '0;
        stopped_nxt     = 1'b0;
      end
    end else begin
      // header typing
      if (idx_r == IDX_W'(3)) begin
        type3_nxt = in_byte_r;
      end
      if (idx_r == IDX_W'(4) && !stopped_r) begin
        if (type3_r == CH_M && in_byte_r == CH_C) begin
          kind_nxt = KIND_RMC;
        end else if (type3_r == CH_G && in_byte_r == CH_A) begin
          kind_nxt = KIND_GGA;
        end
      end

      // field extraction
      if (idx_r >= IDX_W'(5) && kind_r != KIND_NONE && !stopped_r) begin
        if (kind_r == KIND_RMC && comma_r == 4'd2 && fcc_r == 4'd0 && in_byte_r != CH_A) begin
          f_emit      = 1'b1;
          f_tag       = TAG_VOID;
          stopped_nxt = 1'b1;
        end else if (kind_r == KIND_GGA && comma_r == 4'd1 && fcc_r == 4'd0 && is_comma) begin
          stopped_nxt = 1'b1;
        end else if (comma_r == lat_f && !is_comma && fcc_r < MAXC) begin
          f_emit = 1'b1;
          f_tag  = TAG_LAT;
        end else if (comma_r == lat_f + 4'd1 && fcc_r == 4'd0) begin
          f_emit = 1'b1;
          f_tag  = TAG_LAT_HEM;
        end else if (comma_r == lat_f + 4'd2 && !is_comma && fcc_r < MAXC) begin
          f_emit = 1'b1;
          f_tag  = TAG_LON;
        end else if (comma_r == lat_f + 4'd3 && fcc_r == 4'd0) begin
          f_emit = 1'b1;
          f_tag  = TAG_LON_HEM;
        end
      end else if (idx_r < IDX_W'(3) && is_comma) begin
        stopped_nxt = 1'b1;
      end

      // field counters
      if (is_comma) begin
        if (comma_r != 4'hF) begin
          comma_nxt = comma_r + 4'd1;
        end
        fcc_nxt = '0;
      end else if (fcc_r != 4'hF) begin
        fcc_nxt = fcc_r + 4'd1;
      end

      // sentence end
      if (idx_r == IDX_LAST) begin
        end_emit        = (kind_r != KIND_NONE);
        in_sentence_nxt = 1'b0;
        idx_nxt         = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // pack the results of this byte
  always_comb begin
    stype = (kind_r == KIND_GGA);
    res0  = '{tag: TAG_END, char_value: 8'd0, sentence_type: stype, last: 1'b1};
    res1  = '{tag: TAG_END, char_value: 8'd0, sentence_type: stype, last: 1'b1};
    nres  = 2'd0;
    if (f_emit) begin
      res0 = '{tag: f_tag, char_value: in_byte_r, sentence_type: stype, last: !end_emit};
      nres = end_emit ? 2'd2 : 2'd1;
    end else if (end_emit) begin
      nres = 2'd1;
    end
  end

  assign fire       = in_vld_r && (nres == 2'd0 || buf_space);
  assign byte_ready = !in_vld_r || fire;

  assign push.valid  = fire && (nres != 2'd0);
  assign push.count  = nres;
  assign push.first  = res0;
  assign push.second = res1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_byte_r <= byte_data;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      idx_r         <= '0;
      type3_r       <= '0;
      kind_r        <= KIND_NONE;
      comma_r       <= '0;
      fcc_r         <= '0;
      stopped_r     <= 1'b0;
    end else if (fire) begin
      in_sentence_r <= in_sentence_nxt;
      idx_r         <= idx_nxt;
      type3_r       <= type3_nxt;
      kind_r        <= kind_nxt;
      comma_r       <= comma_nxt;
      fcc_r         <= fcc_nxt;
      stopped_r     <= stopped_nxt;
    end
  end

endmodule

### hdl/npfe_outbuf.sv
module npfe_outbuf import npfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    buf_space,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [1:0] cnt_r;
  result_t    slot0_r, slot1_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && res_ready;
  assign buf_space = (cnt_r == 2'd0) || (cnt_r == 2'd1 && res_ready);
  assign res_valid = (cnt_r != 2'd0);
  assign res       = slot0_r;

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push.valid) begin
      cnt_r <= push.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // result slots, head in slot0
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot0_r <= push.first;
      slot1_r <= push.second;
    end else if (pop && cnt_r == 2'd2) begin
      slot0_r <= slot1_r;
    end
  end

endmodule

### hdl/nmea_position_field_extractor.sv
// NMEA position field extractor for RMC and GGA sentences.
// in_chan carries one received serial byte per beat (valid/ready). A '$'
// opens a sentence of SENTENCE_BYTES body bytes; latitude, longitude and
// their hemisphere characters come out on out_chan as tagged beats, with
// an end beat on the last body byte of every RMC or GGA sentence.
// A taken byte is held in the input register while it is parsed, and its
// results are registered into the result buffer that drives out_chan.
// Throughput: one byte per cycle when out_chan does not stall, set by the
// single parse step between the input register and the two-entry result
// buffer; a byte that yields two results (last field character plus end)
// holds back the next result-giving byte while the first of them is taken.
// Reset (rst_n low at a clock edge) empties the input register and the
// result buffer and puts the parser back to waiting for '$'.
// When out_chan stalls, the waiting result holds steady, bytes that give no
// result keep being parsed, and the first byte that gives a result waits in
// the input register while in_chan ready drops.
module nmea_position_field_extractor import npfe_pkg::*; #(
  parameter int SENTENCE_BYTES  = SENTENCE_BYTES_DEF,
  parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  npfe_byte_if.sink    in_chan,
  npfe_res_if.source   out_chan
);

  push_t   push;
  logic    buf_space;
  result_t res;

  npfe_core #(
    .SENTENCE_BYTES (SENTENCE_BYTES),
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(in_chan.valid),
    .byte_data (in_chan.byte_value),
    .byte_ready(in_chan.ready),
    .buf_space (buf_space),
    .push      (push)
  );

  npfe_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .buf_space(buf_space),
    .res_valid(out_chan.valid),
    .res_ready(out_chan.ready),
    .res      (res)
  );

  // result beat fields
  assign out_chan.tag           = res.tag;
  assign out_chan.char_value    = res.char_value;
  assign out_chan.sentence_type = res.sentence_type;
  assign out_chan.last          = res.last;

endmodule

### hdl/npfe_checker.sv
`include "assert_macros.svh"

module npfe_checker import npfe_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_tag,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a stalled result beat keeps its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_tag) && $stable(out_char) && $stable(out_last))

  // the end beat carries no character and closes its byte
  `ASSERT_IMPLY(a_end_form, clk, rst_n, out_valid && out_tag == TAG_END, out_char == 8'd0 && out_last)

  // a beat that is not last is followed at once by the end beat
  `ASSERT_NEXT(a_pair_follow, clk, rst_n, out_valid && out_ready && !out_last, out_valid && out_tag == TAG_END)

  // reset leaves no result pending
  `ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid)

endmodule

bind nmea_position_field_extractor npfe_checker u_npfe_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_tag  (out_chan.tag),
  .out_char (out_chan.char_value),
  .out_last (out_chan.last)
);
